/* rtl/core/bfie_pkg.sv */
// Package for the big-endian bit field insert/extract block.
// Holds store geometry constants, the controller state type and memory port structs.
// No dependencies.
`default_nettype none

package bfie_pkg;

  // Store geometry
  localparam int unsigned BufBytes  = 2048;
  localparam int unsigned MaxWidth  = 32;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned BankRows  = BufBytes / 8;       // two 32-bit words per row pair
  localparam int unsigned BankAw    = $clog2(BankRows);
  localparam int unsigned ClrW      = BankAw + 1;

  // Input and register field widths
  localparam int unsigned OffW      = 14;
  localparam int unsigned WidW      = 6;
  localparam int unsigned LenW      = 12;
  localparam int unsigned WordIdxW  = OffW - 5;
  localparam int unsigned LimW      = 20;

  // Command codes
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdRead  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS
  } bfie_state_e;

  // Read request to both banks
  typedef struct packed {
    logic              en;
    logic [BankAw-1:0] row_even;
    logic [BankAw-1:0] row_odd;
  } bfie_rd_t;

  // Write request to both banks
  typedef struct packed {
    logic                en;
    logic [BankAw-1:0]   row_even;
    logic [BankAw-1:0]   row_odd;
    logic [WordBits-1:0] data_even;
    logic [WordBits-1:0] data_odd;
  } bfie_wr_t;

endpackage

`default_nettype wire

/* rtl/core/bfie_store.sv */
// Packet store: two banks of 32-bit words (even and odd word index).
// One read and one write per bank per cycle, read data registered. Depends on bfie_pkg.
`default_nettype none

module bfie_store
  import bfie_pkg::*;
(
  input  wire logic                clk_i,
  input  wire bfie_rd_t            rd_i,
  input  wire bfie_wr_t            wr_i,
  output logic [WordBits-1:0]      rdata_even_o,
  output logic [WordBits-1:0]      rdata_odd_o
);

  logic [WordBits-1:0] even_mem [BankRows];
  logic [WordBits-1:0] odd_mem  [BankRows];

  // Even bank
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      even_mem[wr_i.row_even] <= wr_i.data_even;
    end
    if (rd_i.en) begin
      rdata_even_o <= even_mem[rd_i.row_even];
    end
  end

  // Odd bank
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      odd_mem[wr_i.row_odd] <= wr_i.data_odd;
    end
    if (rd_i.en) begin
      rdata_odd_o <= odd_mem[rd_i.row_odd];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bit_field_insert_extract.sv */
// Big-endian bit field insert/extract over a byte-addressed packet store.
// The bank read is registered in the store, the result in the output register.
// A new item waits until the last is done (bank read, then modify and write-back).
// Reset: a clearing pass zeroes the store, one row of both banks per cycle,
// all BufBytes/8 rows (256); no item is accepted meanwhile, config writes are.
`default_nettype none

module bit_field_insert_extract
  import bfie_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [LenW-1:0]     cfg_buffer_length_i,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                command_i,
  input  wire logic [OffW-1:0]     bit_offset_i,
  input  wire logic [WidW-1:0]     field_width_i,
  input  wire logic [31:0]         value_i,
  // output channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [31:0]              read_value_o,
  output logic                     range_error_o
);

  bfie_state_e state_q, state_d;

  logic [LenW-1:0]     buf_len_q;
  logic [ClrW-1:0]     clr_cnt_q;

  // item registers
  logic                cmd_q;
  logic [4:0]          shift_q;
  logic [WidW-1:0]     wid_q;
  logic [31:0]         val_q;
  logic                err_q;
  logic                odd_q;
  logic [BankAw-1:0]   row_even_q;
  logic [BankAw-1:0]   row_odd_q;

  logic                out_valid_q;
  logic [31:0]         read_value_q;
  logic                range_error_q;

  logic                accept;
  logic                finish;
  logic                clearing;

  bfie_rd_t            rd_req;
  bfie_wr_t            wr_req;
  logic [WordBits-1:0] rdata_even;
  logic [WordBits-1:0] rdata_odd;

  // Configuration register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_len_q <= LenW'(2048);
    end else if (cfg_valid_i) begin
      buf_len_q <= cfg_buffer_length_i;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == ClrW'(BankRows - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_ACCESS;
      end
      ST_ACCESS: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o = 1'b1;
    clearing   = 1'b0;
    finish     = 1'b0;
    case (state_q)
      ST_CLEAR:  clearing   = 1'b1;
      ST_IDLE:   in_stall_o = 1'b0;
      ST_ACCESS: finish     = !out_valid_q || !out_stall_i;
      default:   in_stall_o = 1'b1;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (clearing) clr_cnt_q <= clr_cnt_q + ClrW'(1);
    end
  end

  // Decode of the incoming item: width saturation, range check, bank rows
  logic [WidW-1:0]     wid_sat;
  logic [LimW-1:0]     lim_bytes;
  logic [LimW-1:0]     lim_bits;
  logic [LimW-1:0]     field_end;
  logic                in_err;
  logic [WordIdxW-1:0] word_idx;
  logic [WordIdxW-2:0] half_idx;

  always_comb begin
    wid_sat   = (field_width_i > WidW'(MaxWidth)) ? WidW'(MaxWidth) : field_width_i;
    lim_bytes = (LimW'(buf_len_q) > LimW'(BufBytes)) ? LimW'(BufBytes) : LimW'(buf_len_q);
    lim_bits  = lim_bytes << 3;
    field_end = LimW'(bit_offset_i) + LimW'(wid_sat);
    in_err    = (wid_sat != '0) && (field_end > lim_bits);
    word_idx  = bit_offset_i[OffW-1:5];
    half_idx  = word_idx[WordIdxW-1:1];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= command_i;
      shift_q <= bit_offset_i[4:0];
      wid_q   <= wid_sat;
      val_q   <= value_i;
      err_q   <= in_err;
      odd_q   <= word_idx[0];
      row_odd_q <= BankAw'(half_idx);
      // next even word follows an odd start word; wraps past the last row
      if (word_idx[0]) begin
        row_even_q <= BankAw'(half_idx) + BankAw'(1);
      end else begin
        row_even_q <= BankAw'(half_idx);
      end
    end
  end

  always_comb begin
    rd_req.en       = accept;
    rd_req.row_odd  = BankAw'(half_idx);
    rd_req.row_even = word_idx[0] ? BankAw'(half_idx) + BankAw'(1) : BankAw'(half_idx);
  end

  // Modify: 64-bit window of the two words, field MSB-first from shift_q
  logic [63:0] window;
  logic [63:0] mask64;
  logic [6:0]  lsb_pos;
  logic [63:0] fmask;
  logic [63:0] new_window;
  logic [63:0] rd_window;
  logic [31:0] rd_field;
  logic        do_write;

  always_comb begin
    window     = odd_q ? {rdata_odd, rdata_even} : {rdata_even, rdata_odd};
    mask64     = (64'd1 << wid_q) - 64'd1;
    lsb_pos    = 7'd64 - 7'(shift_q) - 7'(wid_q);
    fmask      = mask64 << lsb_pos;
    new_window = (window & ~fmask) | (({32'd0, val_q} & mask64) << lsb_pos);
    rd_window  = (window >> lsb_pos) & mask64;
    rd_field   = rd_window[31:0];
    do_write   = finish && (cmd_q == CmdWrite) && !err_q && (wid_q != '0);
  end

  // Write-back, or zero fill during the clearing pass
  always_comb begin
    if (clearing) begin
      wr_req.en        = 1'b1;
      wr_req.row_even  = clr_cnt_q[BankAw-1:0];
      wr_req.row_odd   = clr_cnt_q[BankAw-1:0];
      wr_req.data_even = '0;
      wr_req.data_odd  = '0;
    end else begin
      wr_req.en        = do_write;
      wr_req.row_even  = row_even_q;
      wr_req.row_odd   = row_odd_q;
      wr_req.data_even = odd_q ? new_window[31:0]  : new_window[63:32];
      wr_req.data_odd  = odd_q ? new_window[63:32] : new_window[31:0];
    end
  end

  bfie_store u_store (
    .clk_i        (clk_i),
    .rd_i         (rd_req),
    .wr_i         (wr_req),
    .rdata_even_o (rdata_even),
    .rdata_odd_o  (rdata_odd)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      read_value_q  <= (cmd_q == CmdRead && !err_q) ? rd_field : 32'd0;
      range_error_q <= err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = read_value_q;
  assign range_error_o = range_error_q;

endmodule

`default_nettype wire
